// ===== rtl/base64_encoder_line_wrap_defines.svh =====
// Assertion macros for the Base64 line-wrap encoder RTL.
`ifndef BASE64_ENCODER_LINE_WRAP_DEFINES_SVH
`define BASE64_ENCODER_LINE_WRAP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define B64LW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define B64LW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/b64lw_pkg.sv =====
// Package with constants and the alphabet function for the Base64 line-wrap encoder.
package b64lw_pkg;

    localparam int LINE_COUNT_BITS_DEFAULT = 11;
    localparam int LINE_WIDTH_BITS         = 10;
    localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RESET = 10'd76;
    localparam int MAX_CHARS   = 6;
    localparam int CHAR_CNT_W  = 3;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    typedef logic [7:0] char_t;

    // Map a six-bit value to its character in the standard alphabet.
    function automatic char_t b64_char(input logic [5:0] six);
        char_t c;
        if (six < 6'd26) begin
            c = 8'd65 + {2'b00, six};
        end else if (six < 6'd52) begin
            c = 8'd71 + {2'b00, six};
        end else if (six < 6'd62) begin
            c = {2'b00, six} - 8'd4;
        end else if (six == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// ===== rtl/base64_encoder_line_wrap.sv =====
// Base64 encoder with CR LF line wrapping: input register, group logic and output serializer.
//
// Usage: raw message bytes enter on the s_ stream (s_tdata = byte, s_tlast marks the
// final byte of a message). Encoded characters leave on the m_ stream, one per word:
// m_tdata is the character, m_tlast marks the last character caused by one input
// byte, m_tuser marks the final character of the whole message. Every third byte
// yields four characters, plus CR LF when the line count reaches line_width; a short
// final group yields two or three characters padded with '=' to four.
// cfg_we/cfg_data write line_width (0 turns line breaks off); write it only when idle.
// Flow: a byte taken sits in the input register, is then encoded into the character
// buffer, and its first character moves on into the output register and onto m_tdata.
// Throughput: one character per cycle while the receiver does not stall; the
// single-character output register sets this rate.
// Bytes that only fill a group are absorbed while the buffer still drains.
// When the receiver stalls, the output register holds, the buffer fills and s_tready
// drops once a byte that produces characters waits in the input register.
// Reset empties all stages, clears the pending group and line count and sets
// line_width to 76.
module base64_encoder_line_wrap
    import b64lw_pkg::*;
#(
    parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration.
    input  logic                       cfg_we,
    input  logic [LINE_WIDTH_BITS-1:0] cfg_data,   // line_width
    // Byte input.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,    // data_byte
    input  logic                       s_tlast,    // last_byte
    // Character output.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,    // out_char
    output logic                       m_tlast,    // run_last
    output logic                       m_tuser     // message_end
);

    `include "base64_encoder_line_wrap_defines.svh"

    localparam int CMP_W = (LINE_COUNT_BITS > LINE_WIDTH_BITS) ? LINE_COUNT_BITS
                                                                : LINE_WIDTH_BITS;

    // Configuration and encoder state.
    logic [LINE_WIDTH_BITS-1:0] line_width_reg;
    logic [15:0]                held_reg, held_next;
    logic [1:0]                 fill_reg, fill_next;
    logic [LINE_COUNT_BITS-1:0] count_reg, count_next;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Character buffer for one input word.
    char_t                 burst_chars_reg [MAX_CHARS];
    char_t                 burst_chars_next [MAX_CHARS];
    logic                  burst_valid_reg, burst_valid_next;
    logic [CHAR_CNT_W-1:0] burst_cnt_reg, burst_cnt_next;
    logic [CHAR_CNT_W-1:0] burst_idx_reg, burst_idx_next;
    logic                  burst_end_reg, burst_end_next;

    // Output register.
    logic  out_valid_reg, out_valid_next;
    char_t out_char_reg;
    logic  out_last_reg;
    logic  out_end_reg;

    // Control.
    logic                       out_load;
    logic                       burst_final;
    logic                       burst_free;
    logic [1:0]                 step_fill;
    logic                       full_group;
    logic                       produces;
    logic                       step;
    logic [23:0]                group3;
    logic [17:0]                group2;
    logic [11:0]                group1;
    logic [LINE_COUNT_BITS:0]   count_sum;
    logic [LINE_COUNT_BITS-1:0] count_sat;
    logic                       wrap;

    // Handshake and advance conditions.
    always_comb
    begin
        out_load    = burst_valid_reg && (!out_valid_reg || m_tready);
        burst_final = burst_idx_reg == (burst_cnt_reg - CHAR_CNT_W'(1));
        burst_free  = !burst_valid_reg || (out_load && burst_final);
        step_fill   = (fill_reg == 2'd3) ? 2'd0 : fill_reg;
        full_group  = step_fill == 2'd2;
        produces    = full_group || in_last_reg;
        step        = in_valid_reg && (!produces || burst_free);
        s_tready    = !in_valid_reg || step;
    end

    // Group encoding and line count for the word in the input register.
    always_comb
    begin
        group3    = {held_reg, in_byte_reg};
        group2    = {held_reg[7:0], in_byte_reg, 2'b00};
        group1    = {in_byte_reg, 4'b0000};
        count_sum = {1'b0, count_reg} + (LINE_COUNT_BITS+1)'(4);
        count_sat = count_sum[LINE_COUNT_BITS] ? {LINE_COUNT_BITS{1'b1}}
                                               : count_sum[LINE_COUNT_BITS-1:0];
        wrap      = (line_width_reg != '0)
                 && (CMP_W'(count_sat) >= CMP_W'(line_width_reg));

        held_next  = held_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        for (int i = 0; i < MAX_CHARS; i++)
        begin
            burst_chars_next[i] = burst_chars_reg[i];
        end
        burst_cnt_next = burst_cnt_reg;
        burst_end_next = burst_end_reg;

        if (step)
        begin
            if (full_group)
            begin
                burst_chars_next[0] = b64_char(group3[23:18]);
                burst_chars_next[1] = b64_char(group3[17:12]);
                burst_chars_next[2] = b64_char(group3[11:6]);
                burst_chars_next[3] = b64_char(group3[5:0]);
                burst_chars_next[4] = CHAR_CR;
                burst_chars_next[5] = CHAR_LF;
                burst_cnt_next      = wrap ? CHAR_CNT_W'(6) : CHAR_CNT_W'(4);
                burst_end_next      = in_last_reg;
                count_next          = wrap ? '0 : count_sat;
                held_next           = '0;
                fill_next           = 2'd0;
            end
            else if (in_last_reg)
            begin
                if (step_fill == 2'd0)
                begin
                    burst_chars_next[0] = b64_char(group1[11:6]);
                    burst_chars_next[1] = b64_char(group1[5:0]);
                    burst_chars_next[2] = CHAR_PAD;
                end
                else
                begin
                    burst_chars_next[0] = b64_char(group2[17:12]);
                    burst_chars_next[1] = b64_char(group2[11:6]);
                    burst_chars_next[2] = b64_char(group2[5:0]);
                end
                burst_chars_next[3] = CHAR_PAD;
                burst_cnt_next      = CHAR_CNT_W'(4);
                burst_end_next      = in_last_reg;
            end
            else
            begin
                held_next = {held_reg[7:0], in_byte_reg};
                fill_next = step_fill + 2'd1;
            end
            // End of message starts the next one on a fresh line.
            if (in_last_reg)
            begin
                held_next  = '0;
                fill_next  = 2'd0;
                count_next = '0;
            end
        end
    end

    // Control next state for the input, buffer and output stages.
    always_comb
    begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;

        burst_valid_next = burst_valid_reg;
        burst_idx_next   = burst_idx_reg;
        if (step && produces)
        begin
            burst_valid_next = 1'b1;
            burst_idx_next   = '0;
        end
        else if (out_load)
        begin
            burst_idx_next = burst_idx_reg + CHAR_CNT_W'(1);
            if (burst_final)
            begin
                burst_valid_next = 1'b0;
            end
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= LINE_WIDTH_RESET;
            held_reg        <= '0;
            fill_reg        <= 2'd0;
            count_reg       <= '0;
            in_valid_reg    <= 1'b0;
            burst_valid_reg <= 1'b0;
            burst_idx_reg   <= '0;
            burst_cnt_reg   <= '0;
            burst_end_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                line_width_reg <= cfg_data;
            end
            held_reg        <= held_next;
            fill_reg        <= fill_next;
            count_reg       <= count_next;
            in_valid_reg    <= in_valid_next;
            burst_valid_reg <= burst_valid_next;
            burst_idx_reg   <= burst_idx_next;
            burst_cnt_reg   <= burst_cnt_next;
            burst_end_reg   <= burst_end_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        for (int i = 0; i < MAX_CHARS; i++)
        begin
            burst_chars_reg[i] <= burst_chars_next[i];
        end
        if (out_load)
        begin
            out_char_reg <= burst_chars_reg[burst_idx_reg];
            out_last_reg <= burst_final;
            out_end_reg  <= burst_final && burst_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

    // Consistency checks.
    `B64LW_ASSERT_NOW(a_idx_in_range, burst_valid_reg, burst_idx_reg < burst_cnt_reg,
        "character index beyond buffer count")
    `B64LW_ASSERT_NOW(a_fill_range, 1'b1, fill_reg != 2'd3,
        "group fill reached three")
    `B64LW_ASSERT_NOW(a_end_is_last, m_tvalid && m_tuser, m_tlast,
        "message end without word end")
    `B64LW_ASSERT_NEXT(a_final_char, out_load && burst_final, m_tvalid && m_tlast,
        "final buffered character not marked last")
    `B64LW_ASSERT_NEXT(a_msg_clear, step && in_last_reg,
        (fill_reg == 2'd0) && (count_reg == '0) && (held_reg == '0),
        "state not cleared after message end")

endmodule
